// File: hw/rtl/fpa_pkg.sv
// Shared constants, codes and word types of the Q24.8 fixed-point ALU.
`default_nettype none
package fpa_pkg;

    localparam int WORD_BITS   = 32;
    localparam int FRAC_BITS   = 8;
    localparam int NUM_BITS    = WORD_BITS + FRAC_BITS;
    localparam int PROD_BITS   = 2 * WORD_BITS;
    localparam int MAG_BITS    = PROD_BITS - FRAC_BITS;
    localparam int QUEUE_DEPTH = 4;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [WORD_BITS-1:0] FROM_HI  = WORD_MAX >>> FRAC_BITS;
    localparam logic signed [WORD_BITS-1:0] FROM_LO  = ~FROM_HI;

    typedef enum logic [3:0] {
        F_ADD, F_SUB, F_MUL, F_DIV, F_GT, F_LT, F_GE, F_LE,
        F_EQ, F_NE, F_INC, F_DEC, F_MIN, F_MAX, F_FROM_INT, F_TO_INT
    } fpa_func_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIVZ = 2'd2
    } fpa_status_t;

    typedef enum logic [1:0] {
        K_SIMPLE,
        K_MUL,
        K_DIV
    } fpa_kind_t;

    // one classified word handed from the front to the back
    typedef struct packed {
        fpa_kind_t             kind;
        logic                  neg;
        logic [WORD_BITS-1:0]  ma;
        logic [WORD_BITS-1:0]  mb;
        logic [WORD_BITS-1:0]  value;
        logic                  flag;
        fpa_status_t           status;
    } fpa_entry_t;

    typedef struct packed {
        logic                  push;
        logic                  full;
    } fpa_wr_ctl_t;

    typedef struct packed {
        logic                  head_valid;
        logic                  pop;
    } fpa_rd_ctl_t;

endpackage
`default_nettype wire

// File: hw/rtl/fpa_front.sv
// Front end: accepts input words, computes the simple operations combinationally, tags mul/div.
`default_nettype none
module fpa_front
    import fpa_pkg::*;
(
    input  wire logic                        in_valid,
    input  wire logic [3:0]                  func,
    input  wire logic signed [WORD_BITS-1:0] operand_a,
    input  wire logic signed [WORD_BITS-1:0] operand_b,
    output logic                             in_stall,
    input  wire logic                        full,
    output logic                             push,
    output fpa_entry_t                       entry
);

    logic signed [WORD_BITS:0]   sum;
    logic signed [WORD_BITS-1:0] rhs;
    logic                        do_sub;

    assign in_stall = full;
    assign push     = in_valid && !full;

    always_comb
    begin
        rhs    = operand_b;
        do_sub = 1'b0;
        unique case (fpa_func_t'(func))
            F_SUB:   do_sub = 1'b1;
            F_INC:   rhs = WORD_BITS'(1);
            F_DEC:
            begin
                rhs    = WORD_BITS'(1);
                do_sub = 1'b1;
            end
            default: rhs = operand_b;
        endcase
        if (do_sub)
            sum = {operand_a[WORD_BITS-1], operand_a} - {rhs[WORD_BITS-1], rhs};
        else
            sum = {operand_a[WORD_BITS-1], operand_a} + {rhs[WORD_BITS-1], rhs};
    end

    always_comb
    begin
        entry.kind   = K_SIMPLE;
        entry.neg    = operand_a[WORD_BITS-1] ^ operand_b[WORD_BITS-1];
        entry.ma     = operand_a[WORD_BITS-1] ? -operand_a : operand_a;
        entry.mb     = operand_b[WORD_BITS-1] ? -operand_b : operand_b;
        entry.value  = '0;
        entry.flag   = 1'b0;
        entry.status = ST_OK;
        unique case (fpa_func_t'(func))
            F_ADD, F_SUB, F_INC, F_DEC:
            begin
                if (sum[WORD_BITS] != sum[WORD_BITS-1])
                begin
                    entry.value  = sum[WORD_BITS] ? WORD_MIN : WORD_MAX;
                    entry.status = ST_OVF;
                end
                else
                    entry.value = sum[WORD_BITS-1:0];
            end
            F_MUL:   entry.kind = K_MUL;
            F_DIV:
            begin
                if (operand_b == '0)
                    entry.status = ST_DIVZ;
                else
                    entry.kind = K_DIV;
            end
            F_GT:    entry.flag = operand_a >  operand_b;
            F_LT:    entry.flag = operand_a <  operand_b;
            F_GE:    entry.flag = operand_a >= operand_b;
            F_LE:    entry.flag = operand_a <= operand_b;
            F_EQ:    entry.flag = operand_a == operand_b;
            F_NE:    entry.flag = operand_a != operand_b;
            F_MIN:   entry.value = (operand_a < operand_b) ? operand_a : operand_b;
            F_MAX:   entry.value = (operand_a > operand_b) ? operand_a : operand_b;
            F_FROM_INT:
            begin
                if (operand_a > FROM_HI)
                begin
                    entry.value  = WORD_MAX;
                    entry.status = ST_OVF;
                end
                else if (operand_a < FROM_LO)
                begin
                    entry.value  = WORD_MIN;
                    entry.status = ST_OVF;
                end
                else
                    entry.value = operand_a <<< FRAC_BITS;
            end
            F_TO_INT: entry.value = operand_a >>> FRAC_BITS;
        endcase
    end

endmodule
`default_nettype wire

// File: hw/rtl/fpa_queue.sv
// Short queue of classified words between the front and the back.
`default_nettype none
module fpa_queue
    import fpa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  fpa_entry_t       wr_entry,
    output fpa_wr_ctl_t      wr_ctl,
    input  wire logic        pop,
    output fpa_rd_ctl_t      rd_ctl,
    output fpa_entry_t       head
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

    fpa_entry_t            entries_reg [0:QUEUE_DEPTH-1];
    logic [PTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS:0]     count_reg, count_next;
    logic                  do_pop;

    assign do_pop          = pop && (count_reg != '0);
    assign wr_ctl.push     = push;
    assign wr_ctl.full     = (count_reg == (PTR_BITS+1)'(QUEUE_DEPTH));
    assign rd_ctl.head_valid = (count_reg != '0);
    assign rd_ctl.pop      = do_pop;
    assign head            = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule
`default_nettype wire

// File: hw/rtl/fpa_back.sv
// Back end: multiply, one-bit-per-stage divide, rounding and saturation pipeline.
`default_nettype none
module fpa_back
    import fpa_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 head_valid,
    input  fpa_entry_t                head,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic signed [WORD_BITS-1:0] result_value,
    output logic                      compare_flag,
    output logic [1:0]                status
);

    localparam int STEPS = NUM_BITS;

    typedef struct packed {
        fpa_entry_t             e;
        logic [PROD_BITS-1:0]   prod;
        logic [WORD_BITS-1:0]   rem;
        logic [NUM_BITS-1:0]    nq;
    } stage_t;

    typedef struct packed {
        fpa_entry_t             e;
        logic [MAG_BITS-1:0]    mag;
    } rnd_t;

    stage_t                 stage_reg  [0:STEPS];
    stage_t                 stage_next [0:STEPS];
    logic [STEPS:0]         stage_valid_reg;
    rnd_t                   rnd_reg, rnd_next;
    logic                   rnd_valid_reg;
    logic                   out_valid_reg;
    logic [WORD_BITS-1:0]   value_reg, value_next;
    logic                   flag_reg, flag_next;
    fpa_status_t            status_reg, status_next;
    logic                   adv;

    // shift one quotient bit in; stage 0 also multiplies, stage 1 rounds the product
    function automatic stage_t step(input stage_t s, input int idx);
        stage_t               r;
        logic [WORD_BITS:0]   trial;
        logic                 ge;
        begin
            r     = s;
            trial = {s.rem, s.nq[NUM_BITS-1]};
            ge    = trial >= {1'b0, s.e.mb};
            r.rem = ge ? WORD_BITS'(trial - {1'b0, s.e.mb}) : trial[WORD_BITS-1:0];
            r.nq  = {s.nq[NUM_BITS-2:0], ge};
            if (idx == 0)
                r.prod = s.e.ma * s.e.mb;
            else if (idx == 1)
                r.prod = (s.prod + (PROD_BITS'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
            step = r;
        end
    endfunction

    assign adv          = !out_valid_reg || !out_stall;
    assign pop          = adv && head_valid;
    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign compare_flag = flag_reg;
    assign status       = status_reg;

    always_comb
    begin
        stage_next[0].e    = head;
        stage_next[0].prod = '0;
        stage_next[0].rem  = '0;
        stage_next[0].nq   = {head.ma, {FRAC_BITS{1'b0}}};
        for (int i = 0; i < STEPS; i++)
            stage_next[i+1] = step(stage_reg[i], i);
    end

    // round a quotient half away from zero if 2*rem >= divisor; a product passes as is
    always_comb
    begin
        rnd_next.e = stage_reg[STEPS].e;
        if (stage_reg[STEPS].e.kind == K_MUL)
            rnd_next.mag = stage_reg[STEPS].prod[MAG_BITS-1:0];
        else
            rnd_next.mag = MAG_BITS'(stage_reg[STEPS].nq)
                + MAG_BITS'({stage_reg[STEPS].rem, 1'b0} >= {1'b0, stage_reg[STEPS].e.mb});
    end

    always_comb
    begin
        logic [MAG_BITS-1:0] lim;
        // negative side reaches one past the positive bound
        lim         = rnd_reg.e.neg ? MAG_BITS'({1'b0, WORD_MIN}) : MAG_BITS'({1'b0, WORD_MAX});
        value_next  = rnd_reg.e.value;
        flag_next   = rnd_reg.e.flag;
        status_next = rnd_reg.e.status;
        if (rnd_reg.e.kind != K_SIMPLE)
        begin
            if (rnd_reg.mag > lim)
            begin
                value_next  = rnd_reg.e.neg ? WORD_MIN : WORD_MAX;
                status_next = ST_OVF;
            end
            else if (rnd_reg.e.neg)
                value_next = -rnd_reg.mag[WORD_BITS-1:0];
            else
                value_next = rnd_reg.mag[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            rnd_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            stage_valid_reg <= {stage_valid_reg[STEPS-1:0], pop};
            rnd_valid_reg   <= stage_valid_reg[STEPS];
            out_valid_reg   <= rnd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i <= STEPS; i++)
                stage_reg[i] <= stage_next[i];
            rnd_reg    <= rnd_next;
            value_reg  <= value_next;
            flag_reg   <= flag_next;
            status_reg <= status_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/fixed_point_q24_8_alu_top.sv
// Throughput: one word per cycle while out_stall stays low; the 40-stage divide pipeline sets the latency.
// A 4-word queue decouples the front end from the back-end pipeline.
// Reset (rst_n, async low) clears queue pointers, queue count and pipeline valid bits only.
`default_nettype none
module fixed_point_q24_8_alu_top
    import fpa_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [3:0]                  func,
    input  wire logic signed [WORD_BITS-1:0] operand_a,
    input  wire logic signed [WORD_BITS-1:0] operand_b,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [WORD_BITS-1:0]      result_value,
    output logic                             compare_flag,
    output logic [1:0]                       status
);

    fpa_entry_t   wr_entry;
    fpa_entry_t   head;
    fpa_wr_ctl_t  wr_ctl;
    fpa_rd_ctl_t  rd_ctl;
    logic         push;
    logic         pop;

    fpa_front u_front (
        .in_valid  (in_valid),
        .func      (func),
        .operand_a (operand_a),
        .operand_b (operand_b),
        .in_stall  (in_stall),
        .full      (wr_ctl.full),
        .push      (push),
        .entry     (wr_entry)
    );

    fpa_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .wr_ctl   (wr_ctl),
        .pop      (pop),
        .rd_ctl   (rd_ctl),
        .head     (head)
    );

    fpa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (rd_ctl.head_valid),
        .head         (head),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .compare_flag (compare_flag),
        .status       (status)
    );

endmodule
`default_nettype wire

// File: hw/rtl/fpa_checker.sv
// Port-level checks of the fixed-point ALU and their binding to the top level.
`default_nettype none
module fpa_port_checks
    import fpa_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic signed [WORD_BITS-1:0] result_value,
    input  wire logic                        compare_flag,
    input  wire logic [1:0]                  status
);

    // hold a stalled word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value)
            && $stable(compare_flag) && $stable(status))
        else $error("stalled result word changed");

    a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && compare_flag |-> result_value == '0 && status == ST_OK)
        else $error("compare word carries value or status");

    a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DIVZ |-> result_value == '0 && !compare_flag)
        else $error("divide by zero word not zero");

    a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OVF |-> result_value == WORD_MAX
            || result_value == WORD_MIN)
        else $error("saturated word not at a bound");

endmodule

bind fixed_point_q24_8_alu_top fpa_port_checks u_fpa_port_checks (.*);
`default_nettype wire

// File: tb/fpa_checker.sv
// Checker for the Q24.8 ALU: predicts each result word and compares it.
module fpa_checker
    import fpa_pkg::*;
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic                        in_stall,
    input  wire logic [3:0]                  func,
    input  wire logic signed [WORD_BITS-1:0] operand_a,
    input  wire logic signed [WORD_BITS-1:0] operand_b,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic signed [WORD_BITS-1:0] result_value,
    input  wire logic                        compare_flag,
    input  wire logic [1:0]                  status,
    output int                               errors,
    output int                               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] value;
        logic               flag;
        logic [1:0]         st;
    } alu_word_t;

    alu_word_t expected_words[$];

    function automatic logic signed [31:0] sat64(input logic signed [65:0] v,
                                                inout logic [1:0] st);
        if (v > 66'sd2147483647)
        begin
            st = ST_OVF;
            return WORD_MAX;
        end
        if (v < -66'sd2147483648)
        begin
            st = ST_OVF;
            return WORD_MIN;
        end
        return v[31:0];
    endfunction

    // sign and clamp a magnitude that is already scaled and rounded
    function automatic logic signed [31:0] signed_sat(input logic [127:0] mag, input logic neg,
                                                     inout logic [1:0] st);
        logic [127:0] lim;
        lim = neg ? 128'd2147483648 : 128'd2147483647;
        if (mag > lim)
        begin
            st = ST_OVF;
            return neg ? WORD_MIN : WORD_MAX;
        end
        return neg ? -mag[31:0] : mag[31:0];
    endfunction

    function automatic alu_word_t compute_alu(input logic [3:0] f,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] b);
        alu_word_t r;
        logic [1:0] st;
        logic [127:0] ma, mb, p, q, rem;
        logic neg;
        st = ST_OK;
        r = '0;
        ma = a < 0 ? 128'(-66'(a)) : 128'(a);
        mb = b < 0 ? 128'(-66'(b)) : 128'(b);
        neg = (a < 0) != (b < 0);
        case (fpa_func_t'(f))
            F_ADD: r.value = sat64(66'(a) + 66'(b), st);
            F_SUB: r.value = sat64(66'(a) - 66'(b), st);
            F_MUL:
            begin
                p = (ma * mb + 128'd128) >> FRAC_BITS;
                r.value = signed_sat(p, neg, st);
            end
            F_DIV:
            begin
                if (b == 0)
                    st = ST_DIVZ;
                else
                begin
                    q = (ma << FRAC_BITS) / mb;
                    rem = (ma << FRAC_BITS) % mb;
                    if (rem >= mb - rem)
                        q = q + 1;
                    r.value = signed_sat(q, neg, st);
                end
            end
            F_GT: r.flag = a > b;
            F_LT: r.flag = a < b;
            F_GE: r.flag = a >= b;
            F_LE: r.flag = a <= b;
            F_EQ: r.flag = a == b;
            F_NE: r.flag = a != b;
            F_INC: r.value = sat64(66'(a) + 66'sd1, st);
            F_DEC: r.value = sat64(66'(a) - 66'sd1, st);
            F_MIN: r.value = a < b ? a : b;
            F_MAX: r.value = a > b ? a : b;
            F_FROM_INT: r.value = sat64(66'(a) * 66'sd256, st);
            default: r.value = a >>> FRAC_BITS;
        endcase
        r.st = st;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        alu_word_t w;
        if (!rst_n)
        begin
            errors = 0;
            expected_words.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                expected_words.push_back(compute_alu(func, operand_a, operand_b));
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report_mismatch("unexpected word", result_value, 0);
                else
                begin
                    w = expected_words.pop_front();
                    if (result_value !== w.value)
                        report_mismatch("result_value", result_value, w.value);
                    if (compare_flag !== w.flag)
                        report_mismatch("compare_flag", compare_flag, w.flag);
                    if (status !== w.st)
                        report_mismatch("status", status, w.st);
                end
            end
        end
        pending = expected_words.size();
    end
endmodule

// File: tb/tb_fixed_point_q24_8_alu_top.sv
// Testbench top: drives operations into the ALU and gives the verdict.
module tb_fixed_point_q24_8_alu_top;
    import fpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS = 1930;
    localparam int IDLE_LIMIT   = 20000;

    logic clk, rst_n, in_valid, in_stall, out_valid, out_stall, compare_flag;
    logic [3:0] func;
    logic signed [31:0] operand_a, operand_b, result_value;
    logic [1:0] status;
    int errors, pending, idle_cycles;
    bit hold_off;

    fixed_point_q24_8_alu_top i_dut (.*);

    fpa_checker i_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return 32'($urandom_range(0, 4)) - 2;
            3: return 32'sd256 * ($signed(32'($urandom_range(0, 20))) - 10);
            4: return $signed(32'($urandom_range(0, 8191))) - 4096;
            5: return $signed(32'($urandom_range(0, 16'hffff))) - 32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [3:0] f, input logic signed [31:0] a,
                             input logic signed [31:0] b);
        func <= f;
        operand_a <= a;
        operand_b <= b;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        // at random insert a gap, mostly short and now and then long
        if ($urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    // receiver: random stalls, with a long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (150) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
                out_stall <= 1'b1;
            else
                out_stall <= ($urandom_range(0, 40) == 0);
            if (out_stall && $urandom_range(0, 12) == 0)
                repeat ($urandom_range(10, 50)) @(posedge clk);
        end
    end

    // watchdog on accepted words
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        fpa_func_t f;
        idle_cycles = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = '0;
        operand_a = '0;
        operand_b = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners: every operation, mostly on extreme operands
        send_word(F_ADD, WORD_MAX, 32'sd1);
        send_word(F_ADD, WORD_MIN, -32'sd1);
        send_word(F_SUB, WORD_MIN, 32'sd1);
        send_word(F_SUB, WORD_MAX, WORD_MIN);
        send_word(F_MUL, WORD_MIN, WORD_MIN);
        send_word(F_MUL, 32'sd384, -32'sd1);
        send_word(F_MUL, -32'sd1, 32'sd128);
        send_word(F_DIV, 32'sd256, 32'sd0);
        send_word(F_DIV, WORD_MIN, -32'sd1);
        send_word(F_DIV, 32'sd1, 32'sd512);
        send_word(F_DIV, -32'sd1, 32'sd512);
        send_word(F_GT, WORD_MAX, WORD_MIN);
        send_word(F_LT, WORD_MIN, WORD_MAX);
        send_word(F_GE, 32'sd5, 32'sd5);
        send_word(F_LE, 32'sd6, 32'sd5);
        send_word(F_EQ, WORD_MIN, WORD_MIN);
        send_word(F_NE, 32'sd0, -32'sd1);
        send_word(F_INC, WORD_MAX, 32'sd0);
        send_word(F_DEC, WORD_MIN, 32'sd0);
        send_word(F_MIN, WORD_MIN, WORD_MAX);
        send_word(F_MAX, WORD_MIN, WORD_MAX);
        send_word(F_FROM_INT, 32'sh007fffff, 32'sd0);
        send_word(F_FROM_INT, 32'sh00800000, 32'sd0);
        send_word(F_FROM_INT, -32'sh00800001, 32'sd0);
        send_word(F_TO_INT, -32'sd1, 32'sd0);

        // drain before random traffic; let the checker count the last word first
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == 600)
                hold_off = 1'b1;
            if (i == 1200)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                wait (pending == 0);
                @(posedge clk);
            end
            f = fpa_func_t'($urandom_range(0, 15));
            send_word(f, pick_operand(), pick_operand());
        end
        in_valid <= 1'b0;
        @(posedge clk);

        wait (pending == 0);
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// File: sim.f
hw/rtl/fpa_pkg.sv
hw/rtl/fpa_front.sv
hw/rtl/fpa_queue.sv
hw/rtl/fpa_back.sv
hw/rtl/fixed_point_q24_8_alu_top.sv
hw/rtl/fpa_checker.sv
tb/fpa_checker.sv
tb/tb_fixed_point_q24_8_alu_top.sv
